// ===== rtl/ptf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_pkg: shared types and constants for the PCM to float deinterleaver
// Sample formats, config register indexes and the front-to-back item type.
// ----------------------------------------------------------------------------
package ptf_pkg;

	localparam int MaxChannels = 8;
	localparam int FrameLimit  = 65535;
	localparam int QueueDepth  = 2;

	// sample_format codes
	localparam logic [1:0] FMT_FLOAT32 = 2'd0;
	localparam logic [1:0] FMT_INT16   = 2'd1;
	localparam logic [1:0] FMT_INT32   = 2'd2;
	localparam logic [1:0] FMT_UINT8   = 2'd3;

	// config register indexes
	localparam logic [0:0] REG_CHANNEL_COUNT = 1'd0;
	localparam logic [0:0] REG_SAMPLE_FORMAT = 1'd1;

	// classified item handed from front to back
	typedef struct packed {
		logic [31:0] raw_sample;
		logic [1:0]  sample_format;
		logic [2:0]  channel_index;
		logic [15:0] frame_index;
		logic        is_last;
		logic        partial_frame;
		logic        frame_overflow;
	} item_t;

	// result item
	typedef struct packed {
		logic [31:0] float_bits;
		logic [2:0]  channel_index;
		logic [15:0] frame_index;
		logic        is_last;
		logic        partial_frame;
		logic        frame_overflow;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/ptf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_front: input stage
// Holds the config registers and the channel/frame counters, and tags each
// accepted sample with its destination.
// ----------------------------------------------------------------------------
module ptf_front import ptf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic [31:0] in_raw,
	input  wire logic        in_end,
	output item_t            item
);

	logic [3:0]  channel_count_q;
	logic [1:0]  sample_format_q;
	logic [2:0]  channel_counter_q;
	logic [15:0] frame_counter_q;
	logic        overflow_seen_q;
	logic [2:0]  last_ch;
	logic        closes;

	// effective last channel: 0 acts as 1, clamp at the max
	always_comb begin
		if (channel_count_q == 4'd0)
			last_ch = 3'd0;
		else if (channel_count_q > 4'(MaxChannels))
			last_ch = 3'(MaxChannels - 1);
		else
			last_ch = 3'(channel_count_q - 4'd1);
		closes = channel_counter_q >= last_ch;
	end

	always_comb begin
		item.raw_sample     = in_raw;
		item.sample_format  = sample_format_q;
		item.channel_index  = channel_counter_q;
		item.frame_index    = frame_counter_q;
		item.is_last        = in_end;
		item.partial_frame  = in_end & ~closes;
		item.frame_overflow = overflow_seen_q;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= 4'd1;
			sample_format_q <= FMT_INT16;
		end else if (cfg_we) begin
			if (cfg_index == {1'b0, REG_CHANNEL_COUNT})
				channel_count_q <= cfg_data;
			else if (cfg_index == {1'b0, REG_SAMPLE_FORMAT})
				sample_format_q <= cfg_data[1:0];
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_counter_q <= '0;
			frame_counter_q   <= '0;
			overflow_seen_q   <= 1'b0;
		end else if (in_valid) begin
			if (in_end) begin
				channel_counter_q <= '0;
				frame_counter_q   <= '0;
				overflow_seen_q   <= 1'b0;
			end else if (closes) begin
				channel_counter_q <= '0;
				if (frame_counter_q >= 16'(FrameLimit))
					overflow_seen_q <= 1'b1;
				else
					frame_counter_q <= frame_counter_q + 16'd1;
			end else begin
				channel_counter_q <= channel_counter_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ptf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_queue: two-entry FIFO between front and back
// Lets either side stall without blocking the other.
// ----------------------------------------------------------------------------
module ptf_queue import ptf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output item_t      pop_item
);

	item_t      mem_q [QueueDepth];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'(QueueDepth);
	assign not_empty = cnt_q != 2'd0;
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ptf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_back: conversion stage
// Normalizes the integer forms to a signed 32-bit magnitude, turns it into a
// single with round-to-nearest-even and applies the power-of-two scale in the
// exponent. Result sits in an output register.
// ----------------------------------------------------------------------------
module ptf_back import ptf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    result
);

	logic        sign;
	logic [31:0] mag;
	logic [7:0]  bias;      // exponent of the value 1 at bit 0 after scaling
	logic [4:0]  lz;
	logic [31:0] norm;
	logic [23:0] mant;
	logic        rnd;
	logic [24:0] mant_r;
	logic [8:0]  expo;
	logic [31:0] fbits;
	logic        take;
	logic        found;

	// sign and magnitude per format; bias = 127 - scale shift
	always_comb begin
		sign = 1'b0;
		mag  = '0;
		bias = 8'd127;
		case (item.sample_format)
			FMT_INT16: begin
				sign = item.raw_sample[15];
				mag  = sign ? 32'(17'h10000 - {1'b0, item.raw_sample[15:0]})
				            : {17'd0, item.raw_sample[14:0]};
				bias = 8'(127 - 15);
			end
			FMT_INT32: begin
				sign = item.raw_sample[31];
				mag  = sign ? 32'(0) - item.raw_sample : item.raw_sample;
				bias = 8'(127 - 31);
			end
			FMT_UINT8: begin
				sign = ~item.raw_sample[7];
				mag  = sign ? 32'(8'd128 - item.raw_sample[7:0])
				            : {25'd0, item.raw_sample[6:0]};
				bias = 8'(127 - 7);
			end
			default: ;
		endcase
	end

	// leading one search
	always_comb begin
		lz    = '0;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && mag[i]) begin
				lz    = 5'(31 - i);
				found = 1'b1;
			end
		end
		norm = mag << lz;
	end

	// round to 24 bits, nearest even
	always_comb begin
		mant   = norm[31:8];
		rnd    = norm[7] & ((|norm[6:0]) | norm[8]);
		mant_r = {1'b0, mant} + 25'(rnd);
		expo   = 9'(bias) + 9'd31 - 9'(lz) + 9'(mant_r[24]);
		if (item.sample_format == FMT_FLOAT32)
			fbits = item.raw_sample;
		else if (mag == '0)
			fbits = '0;
		else if (mant_r[24])
			fbits = {sign, expo[7:0], 23'd0};
		else
			fbits = {sign, expo[7:0], mant_r[22:0]};
	end

	assign in_ready = !out_valid || out_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (in_ready)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result.float_bits     <= fbits;
			result.channel_index  <= item.channel_index;
			result.frame_index    <= item.frame_index;
			result.is_last        <= item.is_last;
			result.partial_frame  <= item.partial_frame;
			result.frame_overflow <= item.frame_overflow;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pcm_to_float_deinterleaver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_to_float_deinterleaver: PCM sample to float32 with channel addressing
// Converts interleaved raw samples to normalized singles and tags each with
// its channel and frame.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one raw sample per beat, tlast marks the buffer end.
//  m_axis returns one beat per sample: float bits plus channel, frame and
//  status flags in tdata, is_last on tlast.
//  Config (cfg_we/cfg_index/cfg_data) is written while the block is idle:
//  index 0 channel_count, index 1 sample_format.
//  The path from input beat to output beat runs through the front-to-back
//  queue and then the output register; the converter is combinational.
//  Throughput: one beat per cycle unless the receiver stalls.
//  Reset clears counters and the queue; channel_count returns to 1 and
//  sample_format to int16. When the receiver stalls, the output register
//  and then the two-entry queue fill, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module pcm_to_float_deinterleaver import ptf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // raw_sample
	input  wire logic        s_axis_tlast,   // buffer_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// float_bits[31:0], channel_index[34:32], frame_index[50:35],
	// partial_frame[51], frame_overflow[52], zero fill to 56
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tlast    // is_last
);

	item_t   front_item, q_item;
	result_t res;
	logic    q_full, q_ne, back_ready, accept;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	ptf_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(accept), .in_raw(s_axis_tdata), .in_end(s_axis_tlast),
		.item(front_item)
	);

	ptf_queue u_queue (
		.clk, .arst_n, .push(accept), .push_item(front_item), .full(q_full),
		.pop(q_ne && back_ready), .not_empty(q_ne), .pop_item(q_item)
	);

	ptf_back u_back (
		.clk, .arst_n, .in_valid(q_ne), .in_ready(back_ready), .item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .result(res)
	);

	assign m_axis_tdata = {3'd0, res.frame_overflow, res.partial_frame,
		res.frame_index, res.channel_index, res.float_bits};
	assign m_axis_tlast = res.is_last;

`ifndef SYNTH
	// a partial frame is only flagged on the last beat
	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[51] || m_axis_tlast))
		else $error("partial_frame without tlast");
	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");
	// input is refused only while the queue is full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for pcm_to_float_deinterleaver
// Drives raw samples under random idling and backpressure, predicts the
// float value, channel, frame and status flags of every sample and checks
// each output beat in order. A directed table covers format extremes and
// special patterns; random phases with varying settings follow.
// ----------------------------------------------------------------------------
module tb_top;
	import ptf_pkg::*;

	localparam int CycleLimit = 2000000;

	// one row of the directed table: a register write or a sample beat
	typedef struct {
		bit          is_write;
		logic [1:0]  reg_index;
		logic [3:0]  reg_value;
		logic [31:0] raw;
		bit          last;
		bit          has_float;
		logic [31:0] float_exp;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	// predictor state and shadow registers
	logic [3:0]  chan_count_q;
	logic [1:0]  fmt_q;
	logic [2:0]  chan_ctr;
	logic [15:0] frame_ctr;
	logic        ovf_seen;

	result_t     pending_results[$];
	int          err_count;
	int          cycle_count;
	bit          tx_no_idle;
	bit          rx_no_idle;
	bit          rx_hold;

	pcm_to_float_deinterleaver i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	// signed integer times 2^-shift as a single, rounded to nearest even
	function automatic logic [31:0] int_to_single(longint v, int shift);
		logic [63:0] mag;
		logic [63:0] rem;
		logic [63:0] half;
		int          msb;
		int          drop;
		logic        sgn;
		if (v == 0) begin
			return 32'h0;
		end
		sgn = (v < 0);
		mag = sgn ? 64'(-v) : 64'(v);
		msb = 0;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) begin
				msb = i;
			end
		end
		if (msb > 23) begin
			drop = msb - 23;
			rem  = mag & ((64'd1 << drop) - 64'd1);
			half = 64'd1 << (drop - 1);
			mag  = mag >> drop;
			if (rem > half || (rem == half && mag[0])) begin
				mag = mag + 64'd1;
			end
			if (mag[24]) begin
				mag = mag >> 1;
				msb = msb + 1;
			end
		end else begin
			mag = mag << (23 - msb);
		end
		return {sgn, 8'(msb + 127 - shift), mag[22:0]};
	endfunction

	function automatic logic [31:0] convert_raw(logic [31:0] raw, logic [1:0] fmt);
		case (fmt)
			FMT_FLOAT32: return raw;
			FMT_INT16:   return int_to_single(longint'($signed(raw[15:0])), 15);
			FMT_INT32:   return int_to_single(longint'($signed(raw)), 31);
			default:     return int_to_single(longint'(raw[7:0]) - 128, 7);
		endcase
	endfunction

	// forms the expected beat for one accepted sample and advances counters
	task automatic predict_sample(input logic [31:0] raw, input logic last);
		result_t r;
		int      eff;
		bit      closes;
		eff = (chan_count_q == 0) ? 1 : (chan_count_q > MaxChannels) ? MaxChannels :
			int'(chan_count_q);
		closes = (int'(chan_ctr) >= eff - 1);
		r.float_bits     = convert_raw(raw, fmt_q);
		r.channel_index  = chan_ctr;
		r.frame_index    = frame_ctr;
		r.is_last        = last;
		r.partial_frame  = last && !closes;
		r.frame_overflow = ovf_seen;
		pending_results.push_back(r);
		if (last) begin
			chan_ctr  = '0;
			frame_ctr = '0;
			ovf_seen  = 1'b0;
		end else if (closes) begin
			chan_ctr = '0;
			if (frame_ctr >= FrameLimit) begin
				ovf_seen = 1'b1;
			end else begin
				frame_ctr = frame_ctr + 16'd1;
			end
		end else begin
			chan_ctr = chan_ctr + 3'd1;
		end
	endtask

	// input beat acceptance and output beat check
	always @(posedge clk) begin
		result_t e;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_sample(s_axis_tdata, s_axis_tlast);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected beat: got %h last %b", $time, m_axis_tdata,
					m_axis_tlast);
				err_count++;
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== e.float_bits) begin
					$display("%0t float_bits: exp %h got %h", $time, e.float_bits,
						m_axis_tdata[31:0]);
					err_count++;
				end
				if (m_axis_tdata[34:32] !== e.channel_index) begin
					$display("%0t channel_index: exp %0d got %0d", $time,
						e.channel_index, m_axis_tdata[34:32]);
					err_count++;
				end
				if (m_axis_tdata[50:35] !== e.frame_index) begin
					$display("%0t frame_index: exp %0d got %0d", $time, e.frame_index,
						m_axis_tdata[50:35]);
					err_count++;
				end
				if (m_axis_tlast !== e.is_last) begin
					$display("%0t is_last: exp %b got %b", $time, e.is_last, m_axis_tlast);
					err_count++;
				end
				if (m_axis_tdata[51] !== e.partial_frame) begin
					$display("%0t partial_frame: exp %b got %b", $time, e.partial_frame,
						m_axis_tdata[51]);
					err_count++;
				end
				if (m_axis_tdata[52] !== e.frame_overflow) begin
					$display("%0t frame_overflow: exp %b got %b", $time,
						e.frame_overflow, m_axis_tdata[52]);
					err_count++;
				end
				if (m_axis_tdata[55:53] !== 3'b000) begin
					$display("%0t fill bits: exp 0 got %b", $time, m_axis_tdata[55:53]);
					err_count++;
				end
			end
		end
	end

	// receiver ready
	always @(negedge clk) begin
		if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (rx_no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 32);
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_beat(input logic [31:0] raw, input logic last);
		@(negedge clk);
		while (!tx_no_idle && $urandom_range(99) < 32) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = raw;
		s_axis_tlast  = last;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// waits for the block to drain, then writes one register
	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == 2'(REG_CHANNEL_COUNT)) begin
			chan_count_q = val;
		end else if (idx == 2'(REG_SAMPLE_FORMAT)) begin
			fmt_q = val[1:0];
		end
	endtask

	step_row_t directed[$];

	function automatic step_row_t wr(logic [1:0] idx, logic [3:0] val);
		step_row_t r;
		r = '{1'b1, idx, val, 32'h0, 1'b0, 1'b0, 32'h0};
		return r;
	endfunction

	function automatic step_row_t smp(logic [31:0] raw, bit last, bit chk, logic [31:0] f);
		step_row_t r;
		r = '{1'b0, 2'd0, 4'd0, raw, last, chk, f};
		return r;
	endfunction

	initial begin
		int          len;
		logic [31:0] raw;
		logic [3:0]  cc;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		err_count = 0;
		cycle_count = 0;
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		rx_hold = 1'b0;
		chan_count_q = 4'd1;
		fmt_q = FMT_INT16;
		chan_ctr = '0;
		frame_ctr = '0;
		ovf_seen = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset defaults are int16, one channel
		directed = '{
			smp(32'h0000_8000, 0, 1, 32'hBF80_0000),
			smp(32'hFFFF_7FFF, 0, 1, 32'h3F7F_FE00),
			smp(32'h1234_0000, 1, 1, 32'h0000_0000),
			wr(2'(REG_SAMPLE_FORMAT), 4'(FMT_FLOAT32)),
			smp(32'h7FC0_0001, 0, 1, 32'h7FC0_0001),
			smp(32'hFF80_0000, 0, 1, 32'hFF80_0000),
			wr(2'(REG_SAMPLE_FORMAT), 4'(FMT_INT32)),
			smp(32'h8000_0000, 0, 1, 32'hBF80_0000),
			smp(32'h7FFF_FFFF, 0, 1, 32'h3F80_0000),
			smp(32'h0000_0001, 0, 1, 32'h3000_0000),
			smp(32'h0100_0003, 0, 0, 32'h0),
			wr(2'(REG_SAMPLE_FORMAT), 4'(FMT_UINT8)),
			smp(32'hFFFF_FF00, 0, 1, 32'hBF80_0000),
			smp(32'h0000_00FF, 0, 1, 32'h3F7E_0000),
			smp(32'h0000_0080, 1, 1, 32'h0000_0000),
			// channel count zero acts as one, above the max acts as eight
			wr(2'(REG_CHANNEL_COUNT), 4'd0),
			smp(32'h0000_0011, 0, 0, 32'h0),
			smp(32'h0000_0022, 0, 0, 32'h0),
			wr(2'(REG_CHANNEL_COUNT), 4'd15),
			smp(32'h0000_0033, 0, 0, 32'h0),
			smp(32'h0000_0044, 0, 0, 32'h0),
			// buffer end mid-frame gives a partial frame
			smp(32'h0000_0055, 1, 0, 32'h0),
			wr(2'(REG_CHANNEL_COUNT), 4'd3),
			smp(32'h0000_0066, 0, 0, 32'h0),
			smp(32'h0000_0077, 0, 0, 32'h0)
		};
		foreach (directed[i]) begin
			if (directed[i].is_write) begin
				write_reg(directed[i].reg_index, directed[i].reg_value);
			end else begin
				if (directed[i].has_float &&
					convert_raw(directed[i].raw, fmt_q) !== directed[i].float_exp) begin
					$display("%0t table row %0d: exp %h got %h", $time, i,
						directed[i].float_exp, convert_raw(directed[i].raw, fmt_q));
					err_count++;
				end
				send_beat(directed[i].raw, directed[i].last);
			end
		end

		// random phases: new settings, then frames with random content
		for (int p = 0; p < 24; p++) begin
			cc = (p < 2) ? ((p == 0) ? 4'd8 : 4'd1) : 4'($urandom_range(15));
			write_reg(2'(REG_CHANNEL_COUNT), cc);
			write_reg(2'(REG_SAMPLE_FORMAT), 4'($urandom_range(3)));
			tx_no_idle = (p == 5);
			rx_no_idle = (p == 5);
			if (p == 9) begin
				fork
					begin
						rx_hold = 1'b1;
						repeat (200) @(negedge clk);
						rx_hold = 1'b0;
					end
				join_none
			end
			len = 44 + $urandom_range(40);
			for (int k = 0; k < len; k++) begin
				raw = $urandom;
				if ($urandom_range(3) == 0) begin
					raw = {$urandom_range(1) ? 16'hFFFF : 16'h0000, raw[15:0]};
				end
				send_beat(raw, ($urandom_range(99) < 4));
			end
		end
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;

		// drain
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
